@@ hw/rtl/accm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// accm_pkg
// Shared types and codes of the accumulator machine core.
// ----------------------------------------------------------------------------
package accm_pkg;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_STEP  = 2'd1,
    CMD_START = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_OUTPUT = 3'd1,
    ST_STOP   = 3'd2,
    ST_DIVZ   = 3'd3,
    ST_ILLEGAL = 3'd4,
    ST_HALTED = 3'd5
  } status_e;

  localparam int unsigned OP_ADD    = 1;
  localparam int unsigned OP_SUB    = 2;
  localparam int unsigned OP_MULT   = 3;
  localparam int unsigned OP_DIV    = 4;
  localparam int unsigned OP_JMP    = 5;
  localparam int unsigned OP_JMPN   = 6;
  localparam int unsigned OP_JMPP   = 7;
  localparam int unsigned OP_JMPZ   = 8;
  localparam int unsigned OP_COPY   = 9;
  localparam int unsigned OP_LOAD   = 10;
  localparam int unsigned OP_STORE  = 11;
  localparam int unsigned OP_INPUT  = 12;
  localparam int unsigned OP_OUTPUT = 13;
  localparam int unsigned OP_STOP   = 14;

  localparam int unsigned CmdBits    = 2;
  localparam int unsigned StatusBits = 3;

endpackage

@@ hw/rtl/accm_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// accm_in_if / accm_out_if
// Valid/ready channels carrying command beats and result beats.
// ----------------------------------------------------------------------------
interface accm_in_if #(
  parameter int unsigned AddrBits = 10,
  parameter int unsigned WordBits = 32
);
  logic                valid;
  logic                ready;
  logic [1:0]          command;
  logic [AddrBits-1:0] address;
  logic [WordBits-1:0] data;
  logic [WordBits-1:0] input_value;

  modport source (output valid, command, address, data, input_value, input ready);
  modport sink   (input valid, command, address, data, input_value, output ready);
endinterface

interface accm_out_if #(
  parameter int unsigned AddrBits = 10,
  parameter int unsigned WordBits = 32
);
  logic                valid;
  logic                ready;
  logic [2:0]          status;
  logic [WordBits-1:0] out_value;
  logic [AddrBits-1:0] pc_now;
  logic [WordBits-1:0] acc_now;

  modport source (output valid, status, out_value, pc_now, acc_now, input ready);
  modport sink   (input valid, status, out_value, pc_now, acc_now, output ready);
endinterface

@@ hw/rtl/accumulator_machine_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// accumulator_machine_core
// Accumulator processor over one word memory holding program and data.
//
// Channels: in_i carries command beats (write word, step, start), out_o one
// result beat per command (status, out_value, pc_now, acc_now).
// A write, a start, the unused command or a step while halted passes through
// S_RESP, which registers result valid. A step reads opcode, operand word and
// data word (COPY also its target) through the single memory port, one read
// per cycle, in S_OP, S_ARG, S_ARG2 (COPY only) and S_DAT, executes in S_EXEC
// and, for DIV by nonzero, divides bit-serially in S_DIV and S_DIVF. One item
// is in work at a time; the next command beat is taken in the cycle after the
// result beat is accepted, so a stalled receiver holds the input off till then.
// Reset clears pc, acc, halt and the control state; the memory is undefined
// until written. A stalled receiver holds the result beat stable.
// ----------------------------------------------------------------------------
module accumulator_machine_core
  import accm_pkg::*;
#(
  parameter int unsigned MEM_WORDS = 1024,
  parameter int unsigned WORD_BITS = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  accm_in_if.sink    in_i,
  accm_out_if.source out_o
);

  localparam int unsigned AW = $clog2(MEM_WORDS);
  localparam int unsigned CW = $clog2(WORD_BITS + 1);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_OP    = 10'b0000000010,
    S_ARG   = 10'b0000000100,
    S_DAT   = 10'b0000001000,
    S_ARG2  = 10'b0000010000,
    S_EXEC  = 10'b0000100000,
    S_DIV   = 10'b0001000000,
    S_DIVF  = 10'b0010000000,
    S_RESP  = 10'b0100000000,
    S_CWR   = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  logic [WORD_BITS-1:0] mem [MEM_WORDS];
  logic [WORD_BITS-1:0] rdata_q;
  logic [AW-1:0]        raddr;
  logic                 we;
  logic [AW-1:0]        waddr;
  logic [WORD_BITS-1:0] wdata;

  logic [AW-1:0]        pc_q, pc_d;
  logic [WORD_BITS-1:0] acc_q, acc_d;
  logic                 halt_q, halt_d;
  logic [WORD_BITS-1:0] op_q, op_d, arg_q, arg_d, dat_q, dat_d, inv_q, inv_d;

  logic [WORD_BITS-1:0] dn_q, dn_d, dd_q, dd_d, quo_q, quo_d, rem_q, rem_d;
  logic                 neg_q, neg_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic [WORD_BITS:0]   rem_sh, rem_sub;

  logic                 ov_q, ov_d;
  logic [2:0]           st_q, st_d;
  logic [WORD_BITS-1:0] outv_q, outv_d;

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rdata_q <= mem[raddr];
  end

  function automatic logic [WORD_BITS-1:0] mag(input logic [WORD_BITS-1:0] w);
    mag = w[WORD_BITS-1] ? (~w + 1'b1) : w;
  endfunction

  assign in_i.ready = (state_q == S_IDLE) && !ov_q;
  assign rem_sh  = {rem_q, dn_q[WORD_BITS-1]};
  assign rem_sub = rem_sh - {1'b0, dd_q};

  always_comb begin
    state_d = state_q;
    pc_d = pc_q; acc_d = acc_q; halt_d = halt_q;
    op_d = op_q; arg_d = arg_q; dat_d = dat_q; inv_d = inv_q;
    dn_d = dn_q; dd_d = dd_q; quo_d = quo_q; rem_d = rem_q; neg_d = neg_q; cnt_d = cnt_q;
    ov_d = ov_q; st_d = st_q; outv_d = outv_q;
    raddr = pc_q; we = 1'b0; waddr = in_i.address[AW-1:0]; wdata = in_i.data;
    if (out_o.valid && out_o.ready) ov_d = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_i.valid && in_i.ready) begin
          st_d = ST_OK; outv_d = '0; inv_d = in_i.input_value;
          case (cmd_e'(in_i.command))
            CMD_WRITE: begin
              we = 1'b1; state_d = S_RESP;
            end
            CMD_START: begin
              pc_d = '0; acc_d = '0; halt_d = 1'b0; state_d = S_RESP;
            end
            CMD_STEP: begin
              if (halt_q) begin
                st_d = ST_HALTED; state_d = S_RESP;
              end else begin
                raddr = pc_q; state_d = S_OP;
              end
            end
            default: state_d = S_RESP;
          endcase
        end
      end
      S_OP: begin
        op_d = rdata_q; raddr = pc_q + AW'(1); state_d = S_ARG;
      end
      S_ARG: begin
        arg_d = rdata_q; raddr = rdata_q[AW-1:0];
        state_d = (op_q == WORD_BITS'(OP_COPY)) ? S_ARG2 : S_DAT;
      end
      S_ARG2: begin
        dat_d = rdata_q; raddr = pc_q + AW'(2); state_d = S_DAT;
      end
      S_DAT: begin
        if (op_q == WORD_BITS'(OP_COPY)) arg_d = rdata_q;
        else dat_d = rdata_q;
        state_d = S_EXEC;
      end
      S_EXEC: begin
        state_d = S_RESP;
        case (op_q)
          WORD_BITS'(OP_ADD):  begin acc_d = acc_q + dat_q; pc_d = pc_q + AW'(2); end
          WORD_BITS'(OP_SUB):  begin acc_d = acc_q - dat_q; pc_d = pc_q + AW'(2); end
          WORD_BITS'(OP_MULT): begin acc_d = acc_q * dat_q; pc_d = pc_q + AW'(2); end
          WORD_BITS'(OP_DIV): begin
            pc_d = pc_q + AW'(2);
            if (dat_q == '0) begin
              halt_d = 1'b1; st_d = ST_DIVZ;
            end else begin
              dn_d = mag(acc_q); dd_d = mag(dat_q); rem_d = '0; quo_d = '0;
              neg_d = acc_q[WORD_BITS-1] ^ dat_q[WORD_BITS-1];
              cnt_d = CW'(WORD_BITS); state_d = S_DIV;
            end
          end
          WORD_BITS'(OP_JMP):  pc_d = arg_q[AW-1:0];
          WORD_BITS'(OP_JMPN): pc_d = acc_q[WORD_BITS-1] ? arg_q[AW-1:0] : pc_q + AW'(2);
          WORD_BITS'(OP_JMPP):
            pc_d = (!acc_q[WORD_BITS-1] && acc_q != '0) ? arg_q[AW-1:0] : pc_q + AW'(2);
          WORD_BITS'(OP_JMPZ): pc_d = (acc_q == '0) ? arg_q[AW-1:0] : pc_q + AW'(2);
          WORD_BITS'(OP_COPY): begin
            we = 1'b1; waddr = arg_q[AW-1:0]; wdata = dat_q; pc_d = pc_q + AW'(3);
          end
          WORD_BITS'(OP_LOAD): begin acc_d = dat_q; pc_d = pc_q + AW'(2); end
          WORD_BITS'(OP_STORE): begin
            we = 1'b1; waddr = arg_q[AW-1:0]; wdata = acc_q; pc_d = pc_q + AW'(2);
          end
          WORD_BITS'(OP_INPUT): begin
            we = 1'b1; waddr = arg_q[AW-1:0]; wdata = inv_q; pc_d = pc_q + AW'(2);
          end
          WORD_BITS'(OP_OUTPUT): begin
            outv_d = dat_q; st_d = ST_OUTPUT; pc_d = pc_q + AW'(2);
          end
          WORD_BITS'(OP_STOP): begin halt_d = 1'b1; st_d = ST_STOP; end
          default: begin halt_d = 1'b1; st_d = ST_ILLEGAL; end
        endcase
      end
      S_DIV: begin
        dn_d = {dn_q[WORD_BITS-2:0], 1'b0};
        if (!rem_sub[WORD_BITS]) begin
          rem_d = rem_sub[WORD_BITS-1:0]; quo_d = {quo_q[WORD_BITS-2:0], 1'b1};
        end else begin
          rem_d = rem_sh[WORD_BITS-1:0]; quo_d = {quo_q[WORD_BITS-2:0], 1'b0};
        end
        cnt_d = cnt_q - CW'(1);
        if (cnt_q == CW'(1)) state_d = S_DIVF;
      end
      S_DIVF: begin
        acc_d = neg_q ? (~quo_q + 1'b1) : quo_q; state_d = S_RESP;
      end
      S_RESP: begin
        ov_d = 1'b1; state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; pc_q <= '0; acc_q <= '0; halt_q <= 1'b0; ov_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      state_q <= state_d; pc_q <= pc_d; acc_q <= acc_d; halt_q <= halt_d; ov_q <= ov_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d; arg_q <= arg_d; dat_q <= dat_d; inv_q <= inv_d;
    dn_q <= dn_d; dd_q <= dd_d; quo_q <= quo_d; rem_q <= rem_d; neg_q <= neg_d;
    st_q <= st_d; outv_q <= outv_d;
  end

  assign out_o.valid     = ov_q;
  assign out_o.status    = st_q;
  assign out_o.out_value = outv_q;
  assign out_o.pc_now    = pc_q;
  assign out_o.acc_now   = acc_q;

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for accumulator_machine_core. A short directed table
// covers the edge cases: signed divide overflow, divide by zero, step while
// halted, illegal opcodes, STOP and the unused command. After that, random
// programs are built as execution reaches them, so every word that a step
// uses has been written. Each result beat is compared with an in-bench model
// of the machine, or with the table result a directed row gives. The sender
// runs in bursts, and the receiver stalls, including one long hold-off.
// ----------------------------------------------------------------------------
module tb;
  import accm_pkg::*;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [9:0]  addr;
    logic [31:0] data;
    logic [31:0] in_val;
  } cmd_beat_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] out_value;
    logic [9:0]  pc;
    logic [31:0] acc;
  } result_t;

  typedef struct {
    cmd_beat_t beat;
    logic      typed;
    result_t   res;
  } table_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  accm_in_if  in_ch ();
  accm_out_if out_ch ();

  accumulator_machine_core dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  // machine model
  logic [31:0] mach_mem [1024];
  bit          mach_written [1024];
  logic [9:0]  mach_pc;
  logic [31:0] mach_acc;
  logic        mach_halted;

  result_t    result_q[$];
  table_row_t dir_rows[$];
  int mismatches = 0;
  int beats_sent = 0;
  int beats_checked = 0;
  int status_hits [8];
  bit all_sent = 0;

  function automatic void mem_store(logic [9:0] a, logic [31:0] v);
    mach_mem[a] = v;
    mach_written[a] = 1'b1;
  endfunction

  function automatic logic [31:0] signed_quot(logic [31:0] a, logic [31:0] b);
    logic [31:0] ma, mb, q;
    ma = a[31] ? -a : a;
    mb = b[31] ? -b : b;
    q = ma / mb;
    return (a[31] ^ b[31]) ? -q : q;
  endfunction

  function automatic result_t exec_beat(cmd_beat_t b);
    result_t r;
    logic [9:0] p, a1;
    logic [31:0] op, acc;
    r = '0;
    r.status = ST_OK;
    case (b.cmd)
      CMD_WRITE: mem_store(b.addr, b.data);
      CMD_START: begin
        mach_pc = '0;
        mach_acc = '0;
        mach_halted = 1'b0;
      end
      CMD_STEP: begin
        if (mach_halted) begin
          r.status = ST_HALTED;
        end else begin
          p = mach_pc;
          acc = mach_acc;
          op = mach_mem[p];
          a1 = mach_mem[p + 10'd1][9:0];
          case (op)
            OP_ADD: begin acc = acc + mach_mem[a1]; p = p + 10'd2; end
            OP_SUB: begin acc = acc - mach_mem[a1]; p = p + 10'd2; end
            OP_MULT: begin acc = acc * mach_mem[a1]; p = p + 10'd2; end
            OP_DIV: begin
              p = p + 10'd2;
              if (mach_mem[a1] == 0) begin
                mach_halted = 1'b1;
                r.status = ST_DIVZ;
              end else begin
                acc = signed_quot(acc, mach_mem[a1]);
              end
            end
            OP_JMP: p = a1;
            OP_JMPN: p = acc[31] ? a1 : p + 10'd2;
            OP_JMPP: p = (!acc[31] && acc != 0) ? a1 : p + 10'd2;
            OP_JMPZ: p = (acc == 0) ? a1 : p + 10'd2;
            OP_COPY: begin
              mem_store(mach_mem[p + 10'd2][9:0], mach_mem[a1]);
              p = p + 10'd3;
            end
            OP_LOAD: begin acc = mach_mem[a1]; p = p + 10'd2; end
            OP_STORE: begin mem_store(a1, acc); p = p + 10'd2; end
            OP_INPUT: begin mem_store(a1, b.in_val); p = p + 10'd2; end
            OP_OUTPUT: begin
              r.out_value = mach_mem[a1];
              r.status = ST_OUTPUT;
              p = p + 10'd2;
            end
            OP_STOP: begin mach_halted = 1'b1; r.status = ST_STOP; end
            default: begin mach_halted = 1'b1; r.status = ST_ILLEGAL; end
          endcase
          mach_pc = p;
          mach_acc = acc;
        end
      end
      default: ;
    endcase
    r.pc = mach_pc;
    r.acc = mach_acc;
    return r;
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 32'h0;
      1: return 32'h1;
      2: return 32'hFFFF_FFFF;
      3: return 32'h8000_0000;
      4: return 32'h7FFF_FFFF;
      5: return $urandom_range(0, 50);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_opcode();
    int k;
    k = $urandom_range(0, 99);
    if (k < 4) return OP_STOP;
    if (k < 7) return ($urandom_range(0, 1) == 0) ? 32'd0 : ($urandom | 32'h10);
    return $urandom_range(OP_ADD, OP_OUTPUT);
  endfunction

  function automatic logic [31:0] pick_target();
    if ($urandom_range(0, 9) < 7) return $urandom_range(0, 127);
    return $urandom;
  endfunction

  function automatic bit reads_data(logic [31:0] op);
    return op inside {OP_ADD, OP_SUB, OP_MULT, OP_DIV, OP_COPY, OP_LOAD, OP_OUTPUT};
  endfunction

  // next random beat; fills in whatever words the next step would use
  function automatic cmd_beat_t gen_beat();
    cmd_beat_t b;
    logic [31:0] op;
    logic [9:0] a1;
    int k;
    b.cmd = CMD_STEP;
    b.addr = 10'($urandom);
    b.data = pick_word();
    b.in_val = pick_word();
    k = $urandom_range(0, 99);
    if (k < 8) begin
      b.cmd = CMD_WRITE;
      b.data = $urandom;
      return b;
    end
    if (k < 11 || (mach_halted && k < 60)) begin
      b.cmd = CMD_START;
      // restart builds a fresh program from pc 0
      foreach (mach_written[i]) mach_written[i] = 1'b0;
      return b;
    end
    if (k < 13) begin
      b.cmd = CMD_NONE;
      return b;
    end
    if (mach_halted) return b;
    b.cmd = CMD_WRITE;
    if (!mach_written[mach_pc]) begin
      b.addr = mach_pc;
      b.data = pick_opcode();
      return b;
    end
    op = mach_mem[mach_pc];
    if (!mach_written[mach_pc + 10'd1]) begin
      b.addr = mach_pc + 10'd1;
      b.data = pick_target();
      return b;
    end
    a1 = mach_mem[mach_pc + 10'd1][9:0];
    if (op >= OP_ADD && op <= OP_OUTPUT && reads_data(op) && !mach_written[a1]) begin
      b.addr = a1;
      if (op == OP_DIV && $urandom_range(0, 3) == 0) b.data = 0;
      return b;
    end
    if (op == OP_COPY && !mach_written[mach_pc + 10'd2]) begin
      b.addr = mach_pc + 10'd2;
      b.data = pick_target();
      return b;
    end
    b.cmd = CMD_STEP;
    return b;
  endfunction

  function automatic void add_row(cmd_e c, logic [9:0] a, logic [31:0] d, logic typed,
                                  status_e st, logic [9:0] pc, logic [31:0] acc);
    table_row_t t;
    t.beat.cmd = c;
    t.beat.addr = a;
    t.beat.data = d;
    t.beat.in_val = $urandom;
    t.typed = typed;
    t.res.status = st;
    t.res.out_value = '0;
    t.res.pc = pc;
    t.res.acc = acc;
    dir_rows = {dir_rows, t};
  endfunction

  // ---------------------------------------------------------------- sender
  int burst_left = 0;

  task automatic send_beat(cmd_beat_t b, logic typed, result_t typed_res);
    result_t r;
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
    end
    r = exec_beat(b);
    if (typed) r = typed_res;
    result_q = {result_q, r};
    in_ch.valid <= 1'b1;
    in_ch.command <= b.cmd;
    in_ch.address <= b.addr;
    in_ch.data <= b.data;
    in_ch.input_value <= b.in_val;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    beats_sent++;
    burst_left--;
  endtask

  initial begin
    result_t none;
    none = '0;
    in_ch.valid = 1'b0;
    in_ch.command = CMD_NONE;
    in_ch.address = '0;
    in_ch.data = '0;
    in_ch.input_value = '0;
    mach_pc = '0;
    mach_acc = '0;
    mach_halted = 1'b0;
    foreach (mach_written[i]) mach_written[i] = 1'b0;

    add_row(CMD_WRITE, 10'h3FF, 32'hFFFF_FFFF, 1, ST_OK, 0, 0);
    add_row(CMD_NONE, 0, 0, 1, ST_OK, 0, 0);
    add_row(CMD_WRITE, 0, OP_LOAD, 0, ST_OK, 0, 0);
    add_row(CMD_WRITE, 1, 100, 0, ST_OK, 0, 0);
    add_row(CMD_WRITE, 100, 32'h8000_0000, 0, ST_OK, 0, 0);
    add_row(CMD_STEP, 0, 0, 1, ST_OK, 2, 32'h8000_0000);
    add_row(CMD_WRITE, 2, OP_DIV, 0, ST_OK, 0, 0);
    add_row(CMD_WRITE, 3, 101, 0, ST_OK, 0, 0);
    add_row(CMD_WRITE, 101, 32'hFFFF_FFFF, 0, ST_OK, 0, 0);
    add_row(CMD_STEP, 0, 0, 1, ST_OK, 4, 32'h8000_0000);
    add_row(CMD_WRITE, 4, OP_DIV, 0, ST_OK, 0, 0);
    add_row(CMD_WRITE, 5, 102, 0, ST_OK, 0, 0);
    add_row(CMD_WRITE, 102, 0, 0, ST_OK, 0, 0);
    add_row(CMD_STEP, 0, 0, 1, ST_DIVZ, 6, 32'h8000_0000);
    add_row(CMD_STEP, 0, 0, 1, ST_HALTED, 6, 32'h8000_0000);
    add_row(CMD_START, 0, 0, 1, ST_OK, 0, 0);
    add_row(CMD_WRITE, 0, 15, 1, ST_OK, 0, 0);
    add_row(CMD_STEP, 0, 0, 1, ST_ILLEGAL, 0, 0);
    add_row(CMD_WRITE, 0, 32'hFFFF_FFFF, 1, ST_OK, 0, 0);
    add_row(CMD_START, 0, 0, 1, ST_OK, 0, 0);
    add_row(CMD_STEP, 0, 0, 1, ST_ILLEGAL, 0, 0);
    add_row(CMD_START, 0, 0, 1, ST_OK, 0, 0);
    add_row(CMD_WRITE, 0, OP_STOP, 1, ST_OK, 0, 0);
    add_row(CMD_STEP, 0, 0, 1, ST_STOP, 0, 0);
    add_row(CMD_START, 0, 0, 1, ST_OK, 0, 0);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) send_beat(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].res);
    while (beats_sent < 1050) send_beat(gen_beat(), 1'b0, none);
    in_ch.valid <= 1'b0;
    all_sent = 1;
  end

  // -------------------------------------------------------------- receiver
  initial begin
    int mode, left;
    bit held;
    held = 0;
    mode = 0;
    left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (!held && beats_sent >= 500) begin
        held = 1;
        out_ch.ready <= 1'b0;
        repeat (400) @(posedge clk_i);
      end
      if (left == 0) begin
        mode = $urandom_range(0, 2);
        left = $urandom_range(20, 80);
      end
      left--;
      case (mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= ($urandom_range(0, 3) != 0);
        default: out_ch.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // --------------------------------------------------------------- checker
  always @(posedge clk_i) begin
    result_t want, got;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got.status = out_ch.status;
      got.out_value = out_ch.out_value;
      got.pc = out_ch.pc_now;
      got.acc = out_ch.acc_now;
      status_hits[got.status]++;
      beats_checked++;
      if (result_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat: %p", got);
      end else begin
        want = result_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("beat %0d: expected st=%0d out=%h pc=%0d acc=%h, got st=%0d out=%h pc=%0d acc=%h",
                     beats_checked, want.status, want.out_value, want.pc, want.acc,
                     got.status, got.out_value, got.pc, got.acc);
        end
      end
    end
  end

  // ------------------------------------------------------------------- end
  initial begin
    wait (all_sent);
    while (result_q.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (result_q.size() != 0) mismatches++;
    $display("%0d command beats, %0d results checked, %0d mismatches", beats_sent,
             beats_checked, mismatches);
    $display("status mix: ok %0d out %0d stop %0d divz %0d illegal %0d halted %0d",
             status_hits[0], status_hits[1], status_hits[2], status_hits[3],
             status_hits[4], status_hits[5]);
    if (mismatches == 0) begin
      $display("[accumulator_machine_core] OK");
    end else begin
      $display("[accumulator_machine_core] ERROR");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("[accumulator_machine_core] ERROR");
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/accm_pkg.sv
hw/rtl/accm_if.sv
hw/rtl/accumulator_machine_core.sv
bench/tb.sv
